[design/usg_pkg.sv]
// shared types and constants for the uniform sphere gravity core
`default_nettype none
package usg_pkg;
   localparam int CoordBits = 32;
   localparam logic [34:0] PullK = 35'd17990716939;

   typedef struct packed {
      logic signed [CoordBits-1:0] point_x;
      logic signed [CoordBits-1:0] point_y;
      logic signed [CoordBits-1:0] point_z;
      logic signed [CoordBits-1:0] center_x;
      logic signed [CoordBits-1:0] center_y;
      logic signed [CoordBits-1:0] center_z;
      logic signed [CoordBits-1:0] accum_in_x;
      logic signed [CoordBits-1:0] accum_in_y;
      logic signed [CoordBits-1:0] accum_in_z;
   } req_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] accum_out_x;
      logic signed [CoordBits-1:0] accum_out_y;
      logic signed [CoordBits-1:0] accum_out_z;
      logic                        saturated;
   } rsp_type;
endpackage
`default_nettype wire

[design/uniform_sphere_gravity_core.sv]
// top level of the uniform sphere gravity core
// Usage: req_ carries one query beat (point, centre, incoming pull); rsp_
// returns the incoming pull plus the sphere's pull, saturated, with a flag.
// csr_wr_en/csr_wr_data write the sphere radius (unsigned Q15.16), reset 1.0.
// The radius is sampled deep in the pipeline, so write it only while no beat
// is in flight.
// Throughput: one beat per cycle while rsp_ready does not stall the output; results leave in order.
// The pipeline holds the delta, square, 33-stage square root, force set-up,
// 33-stage ratio divider, radius-ratio product, constant product, force select,
// F*|D| product, 36-stage component dividers (one quotient or root bit per
// stage) and output register stages, in that order.
// A stall on rsp_ready freezes the whole pipeline and drops req_ready;
// nothing is lost or repeated.
// Reset clears every valid bit and restores the radius to 1.0.
`default_nettype none
module uniform_sphere_gravity_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  usg_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output usg_pkg::rsp_type     rsp_data,
   input  wire                  csr_wr_en,
   input  wire  [30:0]          csr_wr_data
);
   import usg_pkg::*;

   // stage budget: 1 delta, 1 square, 33 sqrt, 1 force set-up, 33 ratio divide,
   // 2 force products, 1 force select, 1 F*|D| product, 36 component divide, 1 out
   localparam int SqN = 33;   // sqrt result bits (d2 < 2^66)
   localparam int RdN = 33;   // ratio quotient bits (ratio <= 2^32 outside)
   localparam int CdN = 36;   // component quotient bits (quotient <= force < 2^36)

   logic [30:0] radius_ff;
   always_ff @(posedge clock) begin
      if (reset) radius_ff <= 31'h10000;
      else if (csr_wr_en) radius_ff <= csr_wr_data;
   end

   // global advance: pipeline moves unless output is held
   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage 0: deltas
   typedef struct packed {
      logic        v;
      logic [2:0]  neg;
      logic [32:0] a0, a1, a2;
      logic signed [31:0] acc0, acc1, acc2;
   } s0_type;
   s0_type s0_ff, s0_in;
   logic signed [32:0] dx, dy, dz;
   assign dx = 33'(req_data.center_x) - 33'(req_data.point_x);
   assign dy = 33'(req_data.center_y) - 33'(req_data.point_y);
   assign dz = 33'(req_data.center_z) - 33'(req_data.point_z);
   always_comb begin
      s0_in.v    = req_valid;
      s0_in.neg  = {dz[32], dy[32], dx[32]};
      s0_in.a0   = dx[32] ? 33'(-dx) : 33'(dx);
      s0_in.a1   = dy[32] ? 33'(-dy) : 33'(dy);
      s0_in.a2   = dz[32] ? 33'(-dz) : 33'(dz);
      s0_in.acc0 = req_data.accum_in_x;
      s0_in.acc1 = req_data.accum_in_y;
      s0_in.acc2 = req_data.accum_in_z;
   end
   always_ff @(posedge clock) begin
      if (reset) s0_ff.v <= 1'b0;
      else if (adv) s0_ff <= s0_in;
   end

   // stage 1: squares summed
   typedef struct packed {
      logic        v;
      logic [2:0]  neg;
      logic [32:0] a0, a1, a2;
      logic signed [31:0] acc0, acc1, acc2;
      logic [67:0] d2;
      logic [32:0] root;
   } sq_type;
   sq_type sq_ff [SqN+1];
   sq_type sq0_in;
   always_comb begin
      sq0_in.v    = s0_ff.v;
      sq0_in.neg  = s0_ff.neg;
      sq0_in.a0   = s0_ff.a0;
      sq0_in.a1   = s0_ff.a1;
      sq0_in.a2   = s0_ff.a2;
      sq0_in.acc0 = s0_ff.acc0;
      sq0_in.acc1 = s0_ff.acc1;
      sq0_in.acc2 = s0_ff.acc2;
      sq0_in.d2   = 68'(s0_ff.a0) * 68'(s0_ff.a0) + 68'(s0_ff.a1) * 68'(s0_ff.a1)
                  + 68'(s0_ff.a2) * 68'(s0_ff.a2);
      sq0_in.root = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) sq_ff[0].v <= 1'b0;
      else if (adv) sq_ff[0] <= sq0_in;
   end

   // square root, one result bit per stage: test (root|bit)^2 <= d2
   for (genvar g = 0; g < SqN; g++) begin : g_sqrt
      localparam int B = SqN - 1 - g;
      logic [32:0] cand;
      logic [67:0] csq;
      sq_type      step_in;
      assign cand = sq_ff[g].root | (33'd1 << B);
      assign csq  = 68'(cand) * 68'(cand);
      always_comb begin
         step_in      = sq_ff[g];
         step_in.root = (sq_ff[g].d2 >= csq) ? cand : sq_ff[g].root;
      end
      always_ff @(posedge clock) begin
         if (reset) sq_ff[g+1].v <= 1'b0;
         else if (adv) sq_ff[g+1] <= step_in;
      end
   end

   // force stage: inside force or outside ratio divide set up
   typedef struct packed {
      logic        v;
      logic [2:0]  neg;
      logic [32:0] a0, a1, a2;
      logic signed [31:0] acc0, acc1, acc2;
      logic [32:0] span;
      logic        outside;
      logic [35:0] fin;
      logic [67:0] d2;
      logic [30:0] rad;
      logic        r2_lsb;
      logic [67:0] rem;
      logic [32:0] q;
   } fr_type;
   fr_type fr_ff [RdN+1];
   fr_type fr0_in;
   logic [32:0] sd;
   logic [67:0] kd;
   logic [61:0] rsq;
   assign sd  = sq_ff[SqN].root;
   assign kd  = 68'(PullK) * 68'(sd);
   assign rsq = 62'(radius_ff) * 62'(radius_ff);
   always_comb begin
      fr0_in.v       = sq_ff[SqN].v;
      fr0_in.neg     = sq_ff[SqN].neg;
      fr0_in.a0      = sq_ff[SqN].a0;
      fr0_in.a1      = sq_ff[SqN].a1;
      fr0_in.a2      = sq_ff[SqN].a2;
      fr0_in.acc0    = sq_ff[SqN].acc0;
      fr0_in.acc1    = sq_ff[SqN].acc1;
      fr0_in.acc2    = sq_ff[SqN].acc2;
      fr0_in.span    = sd;
      fr0_in.outside = sd >= 33'(radius_ff);
      fr0_in.fin     = kd[67:32];
      fr0_in.d2      = sq_ff[SqN].d2;
      fr0_in.rad     = radius_ff;
      fr0_in.r2_lsb  = rsq[0];
      // dividend R^2 * 2^32: everything above bit 32 starts as remainder
      fr0_in.rem     = 68'(rsq[61:1]);
      fr0_in.q       = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) fr_ff[0].v <= 1'b0;
      else if (adv) fr_ff[0] <= fr0_in;
   end

   // ratio = floor(R^2*2^32/d2); outside d2 >= R^2, so the quotient is at
   // most 2^32 and the upper dividend bits always sit below d2
   for (genvar g = 0; g < RdN; g++) begin : g_rdiv
      localparam int B = RdN - 1 - g;
      logic [68:0] sh;
      logic        ge;
      fr_type      step_in;
      // dividend bit 32 is the low bit of R^2, bits below it are zero
      assign sh = {fr_ff[g].rem, (B == RdN - 1) ? fr_ff[g].r2_lsb : 1'b0};
      assign ge = sh >= 69'(fr_ff[g].d2);
      always_comb begin
         step_in     = fr_ff[g];
         step_in.rem = ge ? 68'(sh - 69'(fr_ff[g].d2)) : sh[67:0];
         step_in.q   = fr_ff[g].q | (33'(ge) << B);
      end
      always_ff @(posedge clock) begin
         if (reset) fr_ff[g+1].v <= 1'b0;
         else if (adv) fr_ff[g+1] <= step_in;
      end
   end

   fr_type fl;
   assign fl = fr_ff[RdN];

   // outside force, first product: m = R * ratio
   typedef struct packed {
      logic        v;
      logic [2:0]  neg;
      logic [32:0] a0, a1, a2;
      logic signed [31:0] acc0, acc1, acc2;
      logic [32:0] span;
      logic        outside;
      logic [35:0] fin;
      logic [63:0] m;
   } fm_type;
   fm_type fm_ff, fm_in;
   always_comb begin
      fm_in.v       = fl.v;
      fm_in.neg     = fl.neg;
      fm_in.a0      = fl.a0;
      fm_in.a1      = fl.a1;
      fm_in.a2      = fl.a2;
      fm_in.acc0    = fl.acc0;
      fm_in.acc1    = fl.acc1;
      fm_in.acc2    = fl.acc2;
      fm_in.span    = fl.span;
      fm_in.outside = fl.outside;
      fm_in.fin     = fl.fin;
      fm_in.m       = 64'(fl.rad) * 64'(fl.q);
   end
   always_ff @(posedge clock) begin
      if (reset) fm_ff.v <= 1'b0;
      else if (adv) fm_ff <= fm_in;
   end

   // outside force, second product: K*m split into two 32-bit halves
   typedef struct packed {
      logic        v;
      logic [2:0]  neg;
      logic [32:0] a0, a1, a2;
      logic signed [31:0] acc0, acc1, acc2;
      logic [32:0] span;
      logic        outside;
      logic [35:0] fin;
      logic [66:0] ph;
      logic [34:0] pl;
   } fk_type;
   fk_type fk_ff, fk_in;
   logic [66:0] plo;
   assign plo = 67'(PullK) * 67'(fm_ff.m[31:0]);
   always_comb begin
      fk_in.v       = fm_ff.v;
      fk_in.neg     = fm_ff.neg;
      fk_in.a0      = fm_ff.a0;
      fk_in.a1      = fm_ff.a1;
      fk_in.a2      = fm_ff.a2;
      fk_in.acc0    = fm_ff.acc0;
      fk_in.acc1    = fm_ff.acc1;
      fk_in.acc2    = fm_ff.acc2;
      fk_in.span    = fm_ff.span;
      fk_in.outside = fm_ff.outside;
      fk_in.fin     = fm_ff.fin;
      fk_in.ph      = 67'(PullK) * 67'(fm_ff.m[63:32]);
      fk_in.pl      = plo[66:32];
   end
   always_ff @(posedge clock) begin
      if (reset) fk_ff.v <= 1'b0;
      else if (adv) fk_ff <= fk_in;
   end

   // force select: zero distance, outside K*R*ratio >> 64, or inside force
   typedef struct packed {
      logic        v;
      logic [2:0]  neg;
      logic [32:0] a0, a1, a2;
      logic signed [31:0] acc0, acc1, acc2;
      logic [32:0] span;
      logic [35:0] f;
   } fo_type;
   fo_type fo_ff, fo_in;
   logic [67:0] kmr;
   assign kmr = 68'(fk_ff.ph) + 68'(fk_ff.pl);
   always_comb begin
      fo_in.v    = fk_ff.v;
      fo_in.neg  = fk_ff.neg;
      fo_in.a0   = fk_ff.a0;
      fo_in.a1   = fk_ff.a1;
      fo_in.a2   = fk_ff.a2;
      fo_in.acc0 = fk_ff.acc0;
      fo_in.acc1 = fk_ff.acc1;
      fo_in.acc2 = fk_ff.acc2;
      fo_in.span = fk_ff.span;
      if (fk_ff.span == '0) fo_in.f = '0;
      else if (fk_ff.outside) fo_in.f = kmr[67:32];
      else fo_in.f = fk_ff.fin;
   end
   always_ff @(posedge clock) begin
      if (reset) fo_ff.v <= 1'b0;
      else if (adv) fo_ff <= fo_in;
   end

   // F*|D| per axis (36 x 33 bits)
   typedef struct packed {
      logic        v;
      logic [2:0]  neg;
      logic signed [31:0] acc0, acc1, acc2;
      logic [32:0] span;
      logic [68:0] p0, p1, p2;
      logic [32:0] r0, r1, r2;
      logic [35:0] q0, q1, q2;
   } cd_type;
   cd_type cd_ff [CdN+1];
   cd_type cd0_in;
   logic [68:0] pr0, pr1, pr2;
   assign pr0 = 69'(fo_ff.f) * 69'(fo_ff.a0);
   assign pr1 = 69'(fo_ff.f) * 69'(fo_ff.a1);
   assign pr2 = 69'(fo_ff.f) * 69'(fo_ff.a2);
   always_comb begin
      cd0_in.v    = fo_ff.v;
      cd0_in.neg  = fo_ff.neg;
      cd0_in.acc0 = fo_ff.acc0;
      cd0_in.acc1 = fo_ff.acc1;
      cd0_in.acc2 = fo_ff.acc2;
      cd0_in.span = fo_ff.span;
      cd0_in.p0   = pr0;
      cd0_in.p1   = pr1;
      cd0_in.p2   = pr2;
      // quotient stays below 2^36, so the bits above start as remainder
      cd0_in.r0   = pr0[68:CdN];
      cd0_in.r1   = pr1[68:CdN];
      cd0_in.r2   = pr2[68:CdN];
      cd0_in.q0   = '0;
      cd0_in.q1   = '0;
      cd0_in.q2   = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) cd_ff[0].v <= 1'b0;
      else if (adv) cd_ff[0] <= cd0_in;
   end

   // quotient bits of F*|D|/d, one per stage
   for (genvar g = 0; g < CdN; g++) begin : g_cdiv
      localparam int B = CdN - 1 - g;
      logic [33:0] s0, s1, s2;
      logic        g0, g1, g2;
      logic [33:0] dd;
      cd_type      step_in;
      assign dd = 34'(cd_ff[g].span);
      assign s0 = {cd_ff[g].r0, cd_ff[g].p0[B]};
      assign s1 = {cd_ff[g].r1, cd_ff[g].p1[B]};
      assign s2 = {cd_ff[g].r2, cd_ff[g].p2[B]};
      assign g0 = s0 >= dd;
      assign g1 = s1 >= dd;
      assign g2 = s2 >= dd;
      always_comb begin
         step_in    = cd_ff[g];
         step_in.r0 = g0 ? 33'(s0 - dd) : s0[32:0];
         step_in.r1 = g1 ? 33'(s1 - dd) : s1[32:0];
         step_in.r2 = g2 ? 33'(s2 - dd) : s2[32:0];
         step_in.q0 = cd_ff[g].q0 | (36'(g0) << B);
         step_in.q1 = cd_ff[g].q1 | (36'(g1) << B);
         step_in.q2 = cd_ff[g].q2 | (36'(g2) << B);
      end
      always_ff @(posedge clock) begin
         if (reset) cd_ff[g+1].v <= 1'b0;
         else if (adv) cd_ff[g+1] <= step_in;
      end
   end

   // signed add and saturate
   cd_type ce;
   assign ce = cd_ff[CdN];
   function automatic logic [32:0] sat_add(input logic signed [31:0] acc,
                                           input logic [35:0] q,
                                           input logic neg,
                                           input logic zd);
      logic signed [65:0] c, s;
      logic [32:0] r;
      c = zd ? 66'sd0 : (neg ? -$signed({2'b00, q}) : $signed({2'b00, q}));
      s = 66'(acc) + c;
      if (s > 66'sd2147483647) r = {1'b1, 32'h7fffffff};
      else if (s < -66'sd2147483648) r = {1'b1, 32'h80000000};
      else r = {1'b0, s[31:0]};
      return r;
   endfunction

   logic [32:0] o0, o1, o2;
   logic        cz;
   assign cz = ce.span == '0;
   assign o0 = sat_add(ce.acc0, ce.q0, ce.neg[0], cz);
   assign o1 = sat_add(ce.acc1, ce.q1, ce.neg[1], cz);
   assign o2 = sat_add(ce.acc2, ce.q2, ce.neg[2], cz);

   // output register
   rsp_type rsp_in;
   always_comb begin
      rsp_in.accum_out_x = o0[31:0];
      rsp_in.accum_out_y = o1[31:0];
      rsp_in.accum_out_z = o2[31:0];
      rsp_in.saturated   = o0[32] | o1[32] | o2[32];
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) begin
         rsp_valid <= ce.v;
         rsp_data  <= rsp_in;
      end
   end

   // checks
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready mismatch");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      adv && ce.v && cz |=> rsp_valid && !rsp_data.saturated)
      else $error("zero distance saturated");
endmodule
`default_nettype wire

[bench/uniform_sphere_gravity_checker.sv]
// beat monitor, sphere pull predictor and result scoreboard
`timescale 1ns / 1ps
module uniform_sphere_gravity_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_ready,
   input  usg_pkg::req_type  req_data,
   input  wire               rsp_valid,
   input  wire               rsp_ready,
   input  usg_pkg::rsp_type  rsp_data,
   input  wire               csr_wr_en,
   input  wire  [30:0]       csr_wr_data,
   output int                fail_count,
   output int                pending
);
   import usg_pkg::*;

   rsp_type      expected_pull[$];
   logic [30:0]  radius_copy;

   // incoming pull plus this sphere's pull, saturated to the coordinate range
   function automatic rsp_type sphere_pull(req_type q, logic [30:0] rad);
      longint       pt[3], ctr[3], acc[3], delta[3], c, sum;
      logic [127:0] ad[3], d2, span, cand, pull, ratio, rad_w, q_mag;
      rsp_type      r;
      pt  = '{longint'(q.point_x), longint'(q.point_y), longint'(q.point_z)};
      ctr = '{longint'(q.center_x), longint'(q.center_y), longint'(q.center_z)};
      acc = '{longint'(q.accum_in_x), longint'(q.accum_in_y), longint'(q.accum_in_z)};
      rad_w = 128'(rad);
      d2 = '0;
      for (int i = 0; i < 3; i++) begin
         delta[i] = ctr[i] - pt[i];
         ad[i] = 128'(delta[i] < 0 ? -delta[i] : delta[i]);
         d2 = d2 + ad[i] * ad[i];
      end
      // bit-by-bit integer square root
      span = '0;
      for (int b = 40; b >= 0; b--) begin
         cand = span | (128'd1 << b);
         if (cand * cand <= d2)
            span = cand;
      end
      pull = '0;
      if (span != 0) begin
         if (span < rad_w)
            pull = (128'(PullK) * span) >> 32;
         else begin
            ratio = ((rad_w * rad_w) << 32) / d2;
            ratio = ratio & 128'hFFFF_FFFF_FFFF_FFFF;
            pull = (128'(PullK) * rad_w * ratio) >> 64;
         end
      end
      r.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
         c = 0;
         if (span != 0) begin
            q_mag = (pull * ad[i]) / span;
            c = delta[i] < 0 ? -longint'(q_mag) : longint'(q_mag);
         end
         sum = acc[i] + c;
         if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            r.saturated = 1'b1;
         end
         if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            r.saturated = 1'b1;
         end
         case (i)
            0: r.accum_out_x = sum[31:0];
            1: r.accum_out_y = sum[31:0];
            default: r.accum_out_z = sum[31:0];
         endcase
      end
      return r;
   endfunction

   assign pending = expected_pull.size();

   // radius shadow, prediction on request beats, comparison on result beats
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         radius_copy <= 31'd65536;
         fail_count  <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_pull.push_back(sphere_pull(req_data, radius_copy));
         if (rsp_valid && rsp_ready) begin
            if (expected_pull.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("result beat with nothing expected: %h", rsp_data);
            end else begin
               want = expected_pull.pop_front();
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch exp x=%h y=%h z=%h s=%b got x=%h y=%h z=%h s=%b",
                        want.accum_out_x, want.accum_out_y, want.accum_out_z,
                        want.saturated, rsp_data.accum_out_x, rsp_data.accum_out_y,
                        rsp_data.accum_out_z, rsp_data.saturated);
               end
            end
         end
         if (csr_wr_en)
            radius_copy <= csr_wr_data;
      end
   end
endmodule

[bench/uniform_sphere_gravity_core_tb.sv]
// stimulus and verdict for the uniform sphere gravity core
`timescale 1ns / 1ps
module uniform_sphere_gravity_core_tb;
   import usg_pkg::*;

   localparam int DrainCycles = 600;
   localparam int CycleLimit  = 2000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [30:0] csr_wr_data;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   logic        steady;
   logic        hold_request;

   uniform_sphere_gravity_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   uniform_sphere_gravity_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off when asked
   initial begin
      int held;
      bit hold_done;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            for (held = 0; held < 400; held++)
               @(posedge clock);
         end
         rsp_ready <= steady || ($urandom_range(99) >= 28);
      end
   end

   // offer one request beat and wait for it to be taken
   task automatic offer_beat(req_type q);
      logic took;
      if (!steady && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_radius(logic [30:0] rad);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rad;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic req_type make_query(logic signed [31:0] px, logic signed [31:0] py,
         logic signed [31:0] pz, logic signed [31:0] cx, logic signed [31:0] cy,
         logic signed [31:0] cz, logic signed [31:0] ax, logic signed [31:0] ay,
         logic signed [31:0] az);
      req_type q;
      q = '{px, py, pz, cx, cy, cz, ax, ay, az};
      return q;
   endfunction

   // random query, mostly close to the centre so both regions are hit
   function automatic req_type random_query();
      logic signed [31:0] cx, cy, cz, ax, ay, az;
      int                 sh, kind;
      kind = $urandom_range(9);
      cx = $urandom; cy = $urandom; cz = $urandom;
      if (kind < 3) begin
         ax = $urandom; ay = $urandom; az = $urandom;
      end else begin
         ax = $signed($urandom) >>> $urandom_range(4, 24);
         ay = $signed($urandom) >>> $urandom_range(4, 24);
         az = $signed($urandom) >>> $urandom_range(4, 24);
      end
      if (kind == 0)
         return make_query(cx, cy, cz, cx, cy, cz, ax, ay, az);
      if (kind < 3)
         return make_query($urandom, $urandom, $urandom, cx, cy, cz, ax, ay, az);
      sh = $urandom_range(0, 31);
      return make_query(cx + ($signed($urandom) >>> sh), cy + ($signed($urandom) >>> sh),
         cz + ($signed($urandom) >>> sh), cx, cy, cz, ax, ay, az);
   endfunction

   initial begin
      logic [30:0] radii[5];
      req_type     q;
      int          per_phase;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      steady       = 1'b0;
      hold_request = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero distance, extremes, inside, outside, on the surface
      offer_beat(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
      offer_beat(make_query(5, -7, 9, 5, -7, 9, 32'h7FFF_FFFF, 32'h8000_0000, 3));
      offer_beat(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
      offer_beat(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
      offer_beat(make_query(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFF0, 0, 0));
      offer_beat(make_query(0, 0, 0, 32'h8000_0000, 0, 0, 32'h8000_0010, 0, 0));
      offer_beat(make_query(0, 0, 0, 0, 32'h0000_8000, 0, 0, 0, 0));
      offer_beat(make_query(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0));
      offer_beat(make_query(0, 0, 0, 32'h0000_FFFF, 0, 0, 0, 0, 0));
      offer_beat(make_query(0, 0, 0, 1, 0, 0, 0, 0, 0));
      offer_beat(make_query(0, 0, 0, 32'h0003_0000, 32'hFFFC_0000, 32'h0005_0000, 1, 2, 3));
      offer_beat(make_query(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      offer_beat(make_query(0, 32'h0000_4000, 0, 0, 0, 0,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      offer_beat(make_query(32'h0000_4000, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0));
      offer_beat(make_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      offer_beat(make_query(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
         32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0));
      drain_all();

      // radius sweep: smallest, largest and a few between
      radii = '{31'd1, 31'h7FFF_FFFF, 31'd196608, 31'd0, 31'd65536};
      radii[3] = 31'($urandom_range(1, 32'h00FF_FFFF));
      per_phase = 386;
      foreach (radii[p]) begin
         write_radius(radii[p]);
         @(posedge clock);
         steady = (p == 2);
         hold_request = (p == 1);
         for (int n = 0; n < per_phase; n++) begin
            q = random_query();
            offer_beat(q);
         end
         steady = 1'b0;
         hold_request = 1'b0;
         drain_all();
      end

      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
